>>> design/gha_pkg.sv
// Shared types, codes and defaults for the generational handle allocator.
`default_nettype none

package gha_pkg;

    // Field widths fixed by the transaction format.
    localparam int SLOT_W   = 12;
    localparam int EPOCH_W  = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 24;

    // Defaults for the top-level parameters.
    localparam int DEF_SLOT_COUNT = 4096;
    localparam int DEF_EPOCH_BITS = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATE  = 2'd0,
        KIND_DESTROY = 2'd1,
        KIND_CHECK   = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_STALE = 2'd2
    } status_t;

    // One classified request as it sits in the queue between front and back.
    typedef struct packed {
        kind_t               kind;
        logic [SLOT_W-1:0]   slot;
        logic [EPOCH_W-1:0]  epoch;
        logic                slot_ok;
    } req_t;

endpackage

`default_nettype wire

>>> design/gha_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/gha_front.sv
// Front end: accepts requests, classifies the handle range and queues them.
`default_nettype none

module gha_front #(
    parameter int SLOT_COUNT = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 enable,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire gha_pkg::kind_t       in_kind,
    input  wire logic [gha_pkg::SLOT_W-1:0]  in_slot,
    input  wire logic [gha_pkg::EPOCH_W-1:0] in_epoch,
    output logic                      q_valid,
    input  wire logic                 q_ready,
    output gha_pkg::req_t             q_req
);
    import gha_pkg::*;

    localparam int RANGE_W = 21;

    req_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    req_t       req_in;

    // A handle is in range when its slot is nonzero and below the slot count.
    always_comb
    begin
        req_in.kind    = in_kind;
        req_in.slot    = in_slot;
        req_in.epoch   = in_epoch;
        req_in.slot_ok = (in_slot != '0) &&
                         (RANGE_W'(in_slot) < RANGE_W'(SLOT_COUNT));
    end

    assign in_ready = enable && (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_req    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= req_in;
        end
    end

endmodule

`default_nettype wire

>>> design/gha_back.sv
// Back end: executes queued requests against the epoch table and free stack.
`default_nettype none

module gha_back #(
    parameter int SLOT_COUNT = 4096,
    parameter int EPOCH_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    output logic                       ready_for_work,
    input  wire logic                  q_valid,
    output logic                       q_ready,
    input  wire gha_pkg::req_t         q_req,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output gha_pkg::status_t           out_status,
    output logic [gha_pkg::SLOT_W-1:0]  out_slot,
    output logic [gha_pkg::EPOCH_W-1:0] out_epoch
);
    import gha_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [CNT_W-1:0] SLOTS = CNT_W'(SLOT_COUNT);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(SLOT_COUNT - 1);

    typedef enum logic [4:0] {
        S_INIT = 5'b00001,
        S_IDLE = 5'b00010,
        S_POP  = 5'b00100,
        S_EPRD = 5'b01000,
        S_CLR  = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      depth_reg, depth_next;
    logic [CNT_W-1:0]      fresh_reg, fresh_next;
    kind_t                 kind_reg, kind_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;

    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic [EPOCH_W-1:0]    out_epoch_reg, out_epoch_next;

    logic                  ep_we;
    logic [IDX_W-1:0]      ep_waddr;
    logic [EPOCH_BITS-1:0] ep_wdata;
    logic [IDX_W-1:0]      ep_raddr;
    logic [EPOCH_BITS-1:0] ep_rdata;
    logic                  st_we;
    logic [IDX_W-1:0]      st_waddr;
    logic [IDX_W-1:0]      st_raddr;
    logic [IDX_W-1:0]      st_rdata;

    logic                  out_free;
    logic                  load;
    logic                  live;

    gha_ram #(.WIDTH(EPOCH_BITS), .DEPTH(SLOT_COUNT), .AW(IDX_W)) u_epoch_ram (
        .clk   (clk),
        .we    (ep_we),
        .waddr (ep_waddr),
        .wdata (ep_wdata),
        .raddr (ep_raddr),
        .rdata (ep_rdata)
    );

    gha_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT), .AW(IDX_W)) u_stack_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (idx_reg),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign out_free       = !out_valid_reg || out_ready;
    assign live           = (ep_rdata == epoch_reg);
    assign ready_for_work = (state_reg != S_INIT);
    assign st_raddr       = IDX_W'(depth_reg - CNT_W'(1));
    assign st_waddr       = IDX_W'(depth_reg);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        depth_next      = depth_reg;
        fresh_next      = fresh_reg;
        kind_next       = kind_reg;
        idx_next        = idx_reg;
        epoch_next      = epoch_reg;
        q_ready         = 1'b0;
        load            = 1'b0;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_epoch_next  = out_epoch_reg;
        ep_we           = 1'b0;
        ep_waddr        = idx_reg;
        ep_wdata        = EPOCH_BITS'(ep_rdata + EPOCH_BITS'(1));
        ep_raddr        = idx_reg;
        st_we           = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                // Power-up pass that zeroes every epoch.
                ep_we    = 1'b1;
                ep_waddr = IDX_W'(cnt_reg);
                ep_wdata = '0;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                kind_next  = q_req.kind;
                idx_next   = IDX_W'(q_req.slot);
                epoch_next = EPOCH_BITS'(q_req.epoch);
                if (q_req.kind == KIND_CREATE && depth_reg == '0)
                begin
                    idx_next = IDX_W'(fresh_reg);
                end
                ep_raddr = idx_next;
                if (q_valid)
                begin
                    case (q_req.kind)
                        KIND_CREATE:
                        begin
                            if (depth_reg != '0)
                            begin
                                q_ready    = 1'b1;
                                depth_next = depth_reg - CNT_W'(1);
                                state_next = S_POP;
                            end
                            else if (fresh_reg < SLOTS)
                            begin
                                q_ready    = 1'b1;
                                fresh_next = fresh_reg + CNT_W'(1);
                                state_next = S_EPRD;
                            end
                            else if (out_free)
                            begin
                                q_ready         = 1'b1;
                                load            = 1'b1;
                                out_status_next = STATUS_FULL;
                                out_slot_next   = '0;
                                out_epoch_next  = '0;
                            end
                        end
                        KIND_DESTROY, KIND_CHECK:
                        begin
                            if (q_req.slot_ok)
                            begin
                                q_ready    = 1'b1;
                                state_next = S_EPRD;
                            end
                            else if (out_free)
                            begin
                                q_ready         = 1'b1;
                                load            = 1'b1;
                                out_status_next = STATUS_STALE;
                                out_slot_next   = '0;
                                out_epoch_next  = '0;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            q_ready    = 1'b1;
                            cnt_next   = '0;
                            state_next = S_CLR;
                        end
                        default:
                        begin
                            q_ready = 1'b0;
                        end
                    endcase
                end
            end

            S_POP:
            begin
                // The popped slot arrives from the stack; fetch its epoch.
                idx_next   = st_rdata;
                ep_raddr   = st_rdata;
                state_next = S_EPRD;
            end

            S_EPRD:
            begin
                // Read address holds, so the epoch stays put while output waits.
                if (out_free)
                begin
                    load           = 1'b1;
                    state_next     = S_IDLE;
                    out_slot_next  = '0;
                    out_epoch_next = '0;
                    case (kind_reg)
                        KIND_CREATE:
                        begin
                            out_status_next = STATUS_OK;
                            out_slot_next   = SLOT_W'(idx_reg);
                            out_epoch_next  = EPOCH_W'(ep_rdata);
                        end
                        KIND_DESTROY:
                        begin
                            if (live)
                            begin
                                out_status_next = STATUS_OK;
                                ep_we           = 1'b1;
                                if (depth_reg < SLOTS)
                                begin
                                    st_we      = 1'b1;
                                    depth_next = depth_reg + CNT_W'(1);
                                end
                            end
                            else
                            begin
                                out_status_next = STATUS_STALE;
                            end
                        end
                        default:
                        begin
                            out_status_next = live ? STATUS_OK : STATUS_STALE;
                        end
                    endcase
                end
            end

            S_CLR:
            begin
                // Read slot n while writing the bumped epoch of slot n-1.
                ep_waddr = IDX_W'(cnt_reg - CNT_W'(1));
                if (cnt_reg != SLOTS)
                begin
                    ep_raddr = IDX_W'(cnt_reg);
                    ep_we    = (cnt_reg != '0);
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    ep_raddr = IDX_W'(LAST);
                    if (out_free)
                    begin
                        ep_we           = 1'b1;
                        load            = 1'b1;
                        out_status_next = STATUS_OK;
                        out_slot_next   = '0;
                        out_epoch_next  = '0;
                        depth_next      = '0;
                        fresh_next      = CNT_W'(1);
                        state_next      = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            depth_reg     <= '0;
            fresh_reg     <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            depth_reg     <= depth_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        idx_reg        <= idx_next;
        epoch_reg      <= epoch_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_epoch_reg  <= out_epoch_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;
    assign out_epoch  = out_epoch_reg;

endmodule

`default_nettype wire

>>> design/generational_handle_allocator.sv
// Top level of the generational handle allocator.
//
//  Channel   Signals                          Carries
//  -------   -------------------------------  -------------------------------------
//  s_axis    s_tvalid s_tready s_tdata s_tuser request: kind, slot, epoch
//  m_axis    m_tvalid m_tready m_tdata m_tuser response: status, out_slot, out_epoch
//
// Each request transaction yields exactly one response transaction, in order.
// In the execution unit, a request with an invalid slot or an exhausted create
// is answered straight from the idle state; create of a fresh slot, destroy and
// check take one epoch RAM read, then the compare and write back; and create
// of a recycled slot reads the free stack RAM before that. Clear walks the
// epoch RAM one slot per cycle. The request queue registers each request
// ahead of all of this.
// After reset the block zeroes every epoch in the epoch RAM and holds s_tready
// low until that pass is done.
// The two-entry request queue keeps taking requests while a response is
// stalled in the output register; the execution unit waits only when it has
// a response to hand over and the output register is still full.
`default_nettype none

module generational_handle_allocator #(
    parameter int SLOT_COUNT = gha_pkg::DEF_SLOT_COUNT,
    parameter int EPOCH_BITS = gha_pkg::DEF_EPOCH_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [gha_pkg::DATA_W-1:0]  s_tdata,  // [11:0] slot, [19:12] epoch, rest 0
    input  wire logic [gha_pkg::KIND_W-1:0]  s_tuser,  // [1:0] kind
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [gha_pkg::DATA_W-1:0]       m_tdata,  // [11:0] out_slot, [19:12] out_epoch
    output logic [gha_pkg::STATUS_W-1:0]     m_tuser   // [1:0] status
);
    import gha_pkg::*;

    logic               ready_for_work;
    logic               q_valid;
    logic               q_ready;
    req_t               q_req;
    kind_t              in_kind;
    status_t            out_status;
    logic [SLOT_W-1:0]  out_slot;
    logic [EPOCH_W-1:0] out_epoch;

    assign in_kind = kind_t'(s_tuser);

    // The front end classifies the slot range as requests arrive.
    gha_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .enable   (ready_for_work),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (in_kind),
        .in_slot  (s_tdata[SLOT_W-1:0]),
        .in_epoch (s_tdata[SLOT_W+EPOCH_W-1:SLOT_W]),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    // The back end owns the epoch table, the free stack and the output register.
    gha_back #(.SLOT_COUNT(SLOT_COUNT), .EPOCH_BITS(EPOCH_BITS)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .ready_for_work (ready_for_work),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_req          (q_req),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_status     (out_status),
        .out_slot       (out_slot),
        .out_epoch      (out_epoch)
    );

    assign m_tdata = {{(DATA_W - SLOT_W - EPOCH_W){1'b0}}, out_epoch, out_slot};
    assign m_tuser = out_status;

endmodule

`default_nettype wire

>>> tb/handle_allocation_checker.sv
`timescale 1ns / 100ps
// Checker that predicts each allocator response and compares it with the result channel.
module handle_allocation_checker #(
    parameter int SLOT_COUNT = gha_pkg::DEF_SLOT_COUNT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [gha_pkg::DATA_W-1:0]    s_tdata,
    input  logic [gha_pkg::KIND_W-1:0]    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [gha_pkg::DATA_W-1:0]    m_tdata,
    input  logic [gha_pkg::STATUS_W-1:0]  m_tuser,
    output int                            fail_count,
    output int                            outstanding,
    output int                            ok_count,
    output int                            full_count,
    output int                            stale_count,
    output logic                          handle_valid,
    output logic [gha_pkg::SLOT_W-1:0]    handle_slot,
    output logic [gha_pkg::EPOCH_W-1:0]   handle_epoch
);
    import gha_pkg::*;

    typedef struct packed {
        kind_t               kind;
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [EPOCH_W-1:0]  epoch;
    } response_t;

    // Shadow copy of the allocator state.
    logic [EPOCH_W-1:0] epoch_mem [SLOT_COUNT];
    logic [SLOT_W-1:0]  recycle_stack [SLOT_COUNT];
    int                 recycle_depth;
    int                 fresh_slot;

    response_t awaited[$];
    int        reported;

    function automatic logic handle_live(logic [SLOT_W-1:0] slot, logic [EPOCH_W-1:0] epoch);
        return slot != '0 && int'(slot) < SLOT_COUNT && epoch == epoch_mem[slot];
    endfunction

    // Applies one request to the shadow state and returns the response it must produce.
    function automatic response_t predict_response(kind_t kind, logic [SLOT_W-1:0] slot,
                                                   logic [EPOCH_W-1:0] epoch);
        response_t r;
        r.kind   = kind;
        r.status = STATUS_OK;
        r.slot   = '0;
        r.epoch  = '0;
        case (kind)
            KIND_CREATE:
            begin
                if (recycle_depth > 0)
                begin
                    recycle_depth--;
                    r.slot  = recycle_stack[recycle_depth];
                    r.epoch = epoch_mem[r.slot];
                end
                else if (fresh_slot < SLOT_COUNT)
                begin
                    r.slot  = SLOT_W'(fresh_slot);
                    r.epoch = epoch_mem[r.slot];
                    fresh_slot++;
                end
                else
                begin
                    r.status = STATUS_FULL;
                end
            end
            KIND_DESTROY:
            begin
                if (!handle_live(slot, epoch))
                begin
                    r.status = STATUS_STALE;
                end
                else
                begin
                    epoch_mem[slot] = epoch_mem[slot] + 1'b1;
                    // A push onto a full stack is dropped; the epoch still advances.
                    if (recycle_depth < SLOT_COUNT)
                    begin
                        recycle_stack[recycle_depth] = slot;
                        recycle_depth++;
                    end
                end
            end
            KIND_CHECK:
            begin
                if (!handle_live(slot, epoch))
                    r.status = STATUS_STALE;
            end
            default:
            begin
                foreach (epoch_mem[i])
                    epoch_mem[i] = epoch_mem[i] + 1'b1;
                recycle_depth = 0;
                fresh_slot    = 1;
            end
        endcase
        return r;
    endfunction

    task automatic note_failure(string what);
        fail_count++;
        if (reported < 10)
            $display("%0t ns: %s", $time, what);
        reported++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        response_t want;
        if (!rst_n)
        begin
            foreach (epoch_mem[i])
                epoch_mem[i] = '0;
            recycle_depth = 0;
            fresh_slot    = 1;
            awaited.delete();
            fail_count    = 0;
            reported      = 0;
            ok_count      = 0;
            full_count    = 0;
            stale_count   = 0;
            outstanding  <= 0;
            handle_valid <= 1'b0;
            handle_slot  <= '0;
            handle_epoch <= '0;
        end
        else
        begin
            handle_valid <= 1'b0;
            // The result side is handled first, so a result never pairs with a
            // request accepted at the same edge.
            if (m_tvalid && m_tready)
            begin
                case (m_tuser)
                    STATUS_OK:   ok_count++;
                    STATUS_FULL: full_count++;
                    default:     stale_count++;
                endcase
                if (awaited.size() == 0)
                begin
                    note_failure($sformatf("result with nothing pending: status %0d slot %0d epoch %0d",
                                           m_tuser, m_tdata[SLOT_W-1:0],
                                           m_tdata[SLOT_W+EPOCH_W-1:SLOT_W]));
                end
                else
                begin
                    want = awaited.pop_front();
                    if (m_tuser != want.status || m_tdata[SLOT_W-1:0] != want.slot
                        || m_tdata[SLOT_W+EPOCH_W-1:SLOT_W] != want.epoch)
                        note_failure($sformatf({"mismatch on %s: expected status %0d slot %0d ",
                                                "epoch %0d, got status %0d slot %0d epoch %0d"},
                                               want.kind.name(), want.status, want.slot,
                                               want.epoch, m_tuser, m_tdata[SLOT_W-1:0],
                                               m_tdata[SLOT_W+EPOCH_W-1:SLOT_W]));
                    if (want.kind == KIND_CREATE && want.status == STATUS_OK)
                    begin
                        handle_valid <= 1'b1;
                        handle_slot  <= want.slot;
                        handle_epoch <= want.epoch;
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited.push_back(predict_response(kind_t'(s_tuser), s_tdata[SLOT_W-1:0],
                                                   s_tdata[SLOT_W+EPOCH_W-1:SLOT_W]));
            outstanding <= awaited.size();
        end
    end

endmodule

>>> tb/tb_generational_handle_allocator.sv
`timescale 1ns / 100ps
// Testbench top for the generational handle allocator: stimulus, flow control and verdict.
module tb_generational_handle_allocator;
    import gha_pkg::*;

    localparam int SLOT_COUNT   = DEF_SLOT_COUNT;
    localparam int RANDOM_ITEMS = 850;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 5;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int POOL_LIMIT   = 512;
    localparam int RETIRED_KEEP = 64;
    // The limit leaves room for the slowest correct run, including the
    // clearing pass after reset and the clear-all requests.
    localparam int LIMIT_CYCLES = 1000000;

    // Flow-control regimes for the random part of the run.
    typedef enum {
        PH_STEADY,
        PH_SEND_GAPS,
        PH_RECV_STALLS,
        PH_BOTH_IDLE,
        PH_BACKPRESSURE
    } phase_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [EPOCH_W-1:0]  epoch;
    } handle_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [DATA_W-1:0]    s_tdata   = '0;   // [11:0] slot, [19:12] epoch, rest 0
    logic [KIND_W-1:0]    s_tuser   = '0;   // [1:0] kind
    logic                 m_tready  = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [DATA_W-1:0]    m_tdata;          // [11:0] out_slot, [19:12] out_epoch
    logic [STATUS_W-1:0]  m_tuser;          // [1:0] status

    int                   fail_count;
    int                   outstanding;
    int                   ok_count;
    int                   full_count;
    int                   stale_count;
    logic                 handle_valid;
    logic [SLOT_W-1:0]    handle_slot;
    logic [EPOCH_W-1:0]   handle_epoch;

    phase_t               phase       = PH_STEADY;
    int                   idle_pct    = 0;
    int                   stall_pct   = 0;
    int                   sent_count  = 0;
    int                   clear_count = 0;
    int                   cycle_count = 0;
    int                   hold_left   = HOLD_CYCLES;
    logic                 hold_done   = 1'b0;

    // Handles that came back from successful creates, and some that were destroyed.
    handle_t              live_handles[$];
    handle_t              retired_handles[$];

    generational_handle_allocator #(
        .SLOT_COUNT (SLOT_COUNT),
        .EPOCH_BITS (DEF_EPOCH_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    handle_allocation_checker #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .ok_count     (ok_count),
        .full_count   (full_count),
        .stale_count  (stale_count),
        .handle_valid (handle_valid),
        .handle_slot  (handle_slot),
        .handle_epoch (handle_epoch)
    );

    // 8 ns clock: low for the first half period, then high.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a run that hangs anywhere ends here as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d responses pending.",
                     cycle_count, outstanding);
            $display("tb_generational_handle_allocator: errors");
            $finish;
        end
    end

    // Collect handles from successful creates so that later requests can use them.
    always @(posedge clk)
    begin
        if (handle_valid && live_handles.size() < POOL_LIMIT)
            live_handles.push_back('{handle_slot, handle_epoch});
    end

    // Result side flow control. In the backpressure phase the receiver refuses
    // every transaction for a long stretch while the sender keeps offering, so
    // the request queue and output register fill and s_tready drops.
    always @(negedge clk)
    begin
        if (phase == PH_BACKPRESSURE && !hold_done)
        begin
            m_tready <= 1'b0;
            hold_left--;
            if (hold_left == 0)
                hold_done = 1'b1;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Presents one request transaction and returns at the edge that accepts it.
    // The valid stays high between back-to-back transactions; it is lowered only
    // for a sender gap or by wait_idle.
    task automatic send_request(kind_t kind, logic [SLOT_W-1:0] slot,
                                logic [EPOCH_W-1:0] epoch);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DATA_W - SLOT_W - EPOCH_W){1'b0}}, epoch, slot};
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        sent_count++;
        if (kind == KIND_CLEAR)
            clear_count++;
    endtask

    // Drops the valid and waits until every response has come back.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic enter_phase(phase_t next);
        phase = next;
        case (next)
            PH_SEND_GAPS:   begin idle_pct = 51; stall_pct = 0;  end
            PH_RECV_STALLS: begin idle_pct = 0;  stall_pct = 51; end
            PH_BOTH_IDLE:   begin idle_pct = 13; stall_pct = 13; end
            default:        begin idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // Mostly well-formed traffic on handles that were really handed out, with
    // some reuse of destroyed handles, random noise and the odd clear-all.
    task automatic send_random_request();
        int      pick;
        int      idx;
        handle_t h;
        pick = $urandom_range(0, 99);
        if (pick < 30 || (pick < 75 && live_handles.size() == 0))
        begin
            // Slot and epoch are ignored by create but still toggle here.
            send_request(KIND_CREATE, SLOT_W'($urandom_range(0, 4095)),
                         EPOCH_W'($urandom_range(0, 255)));
        end
        else if (pick < 55)
        begin
            idx = $urandom_range(0, live_handles.size() - 1);
            h   = live_handles[idx];
            live_handles.delete(idx);
            retired_handles.push_back(h);
            if (retired_handles.size() > RETIRED_KEEP)
                void'(retired_handles.pop_front());
            send_request(KIND_DESTROY, h.slot, h.epoch);
        end
        else if (pick < 75)
        begin
            h = live_handles[$urandom_range(0, live_handles.size() - 1)];
            send_request(KIND_CHECK, h.slot, h.epoch);
        end
        else if (pick < 85 && retired_handles.size() != 0)
        begin
            h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
            send_request($urandom_range(0, 1) ? KIND_DESTROY : KIND_CHECK, h.slot, h.epoch);
        end
        else if (pick < 99)
        begin
            // Arbitrary handles; slot zero gets a share of its own.
            send_request(kind_t'($urandom_range(0, 2)),
                         ($urandom_range(0, 7) == 0) ? '0 : SLOT_W'($urandom_range(0, 4095)),
                         EPOCH_W'($urandom_range(0, 255)));
        end
        else
        begin
            send_request(KIND_CLEAR, SLOT_W'($urandom_range(0, 4095)),
                         EPOCH_W'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: invalid slot zero, never-issued slots, the top slot,
        // stale destroys, a live handle parked on the free stack, recycling,
        // clear-all, and fields at all-zeros, all-ones and alternating bits.
        enter_phase(PH_STEADY);
        send_request(KIND_CHECK,   12'd0,   8'd0);
        send_request(KIND_DESTROY, 12'd0,   8'hFF);
        send_request(KIND_CHECK,   12'd5,   8'd0);
        send_request(KIND_CHECK,   12'hFFF, 8'd0);
        send_request(KIND_CHECK,   12'hFFF, 8'hFF);
        send_request(KIND_CREATE,  12'hFFF, 8'hFF);
        send_request(KIND_CREATE,  12'd0,   8'd0);
        send_request(KIND_CHECK,   12'd1,   8'd0);
        send_request(KIND_DESTROY, 12'd1,   8'd0);
        send_request(KIND_DESTROY, 12'd1,   8'd0);
        send_request(KIND_CHECK,   12'd1,   8'd1);
        send_request(KIND_CREATE,  12'd0,   8'd0);
        send_request(KIND_DESTROY, 12'hFFF, 8'd0);
        send_request(KIND_CHECK,   12'hFFF, 8'd1);
        send_request(KIND_CREATE,  12'd0,   8'd0);
        send_request(KIND_CLEAR,   12'hFFF, 8'hFF);
        send_request(KIND_CHECK,   12'd1,   8'd1);
        send_request(KIND_CHECK,   12'd1,   8'd2);
        send_request(KIND_CREATE,  12'd0,   8'd0);
        send_request(KIND_DESTROY, 12'hAAA, 8'h55);
        send_request(KIND_CHECK,   12'h555, 8'hAA);
        wait_idle();
        live_handles.delete();
        retired_handles.delete();

        // Random traffic under each flow-control regime in turn.
        enter_phase(PH_STEADY);
        repeat (PHASE_ITEMS) send_random_request();
        enter_phase(PH_SEND_GAPS);
        repeat (PHASE_ITEMS) send_random_request();
        enter_phase(PH_RECV_STALLS);
        repeat (PHASE_ITEMS) send_random_request();
        enter_phase(PH_BOTH_IDLE);
        repeat (PHASE_ITEMS) send_random_request();
        enter_phase(PH_BACKPRESSURE);
        repeat (PHASE_ITEMS) send_random_request();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d clear-all): directed cases, then five random regimes.",
                 sent_count, clear_count);
        $display("Responses: %0d ok, %0d without a free index, %0d stale or invalid; %0d failures.",
                 ok_count, full_count, stale_count, fail_count);
        if (fail_count == 0)
            $display("tb_generational_handle_allocator: clean");
        else
            $display("tb_generational_handle_allocator: errors");
        $finish;
    end

endmodule

>>> generational_handle_allocator.f
design/gha_pkg.sv
design/gha_ram.sv
design/gha_front.sv
design/gha_back.sv
design/generational_handle_allocator.sv
tb/handle_allocation_checker.sv
tb/tb_generational_handle_allocator.sv
